// File: rtl/rrc_pkg.sv
package rrc_pkg;

   // Default sizes of the canvas and of the fixed-point format
   localparam int MAX_SIDE_DEF  = 256;
   localparam int FRAC_BITS_DEF = 8;

   // Field widths
   localparam int COORD_W    = 24;
   localparam int CHAR_W     = 8;
   localparam int POS_W      = 8;
   localparam int CFG_W      = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 8;

   // Request tdata layout, lowest bit up
   localparam int LEFT_LSB   = 0;
   localparam int TOP_LSB    = LEFT_LSB + COORD_W;
   localparam int WIDTH_LSB  = TOP_LSB + COORD_W;
   localparam int HEIGHT_LSB = WIDTH_LSB + COORD_W;
   localparam int FILLED_BIT = HEIGHT_LSB + COORD_W;
   localparam int COLOR_LSB  = FILLED_BIT + 1;
   localparam int COL_LSB    = COLOR_LSB + CHAR_W;
   localparam int ROW_LSB    = COL_LSB + POS_W;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND    = 2'd2;

   // Register reset values
   localparam logic [CFG_W-1:0]  CANVAS_WIDTH_RST  = 9'd256;
   localparam logic [CFG_W-1:0]  CANVAS_HEIGHT_RST = 9'd256;
   localparam logic [CHAR_W-1:0] BACKGROUND_RST    = 8'd46;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_PAINT = 2'd1,
      MODE_READ  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_REJECT  = 2'd1,
      STAT_OUTSIDE = 2'd2
   } status_type;

   // Command from the request control to the raster sweep
   typedef struct packed {
      logic              start;
      logic              clear;
      logic              fill;
      logic [CHAR_W-1:0] color;
   } sweep_cmd_type;

endpackage

// File: rtl/rrc_canvas_mem.sv
module rrc_canvas_mem #(
   parameter int ADDR_W = 16
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [rrc_pkg::CHAR_W-1:0]    wr_data,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [rrc_pkg::CHAR_W-1:0]    rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [rrc_pkg::CHAR_W-1:0] mem [DEPTH];
   logic [rrc_pkg::CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/rrc_sweep.sv
module rrc_sweep #(
   parameter int MAX_SIDE  = rrc_pkg::MAX_SIDE_DEF,
   parameter int FRAC_BITS = rrc_pkg::FRAC_BITS_DEF,
   localparam int CW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
   localparam int SW = $clog2(MAX_SIDE + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rrc_pkg::sweep_cmd_type               cmd,
   input  logic signed [rrc_pkg::COORD_W-1:0]   rect_left,
   input  logic signed [rrc_pkg::COORD_W-1:0]   rect_top,
   input  logic signed [rrc_pkg::COORD_W-1:0]   rect_width,
   input  logic signed [rrc_pkg::COORD_W-1:0]   rect_height,
   input  logic [SW-1:0]                        side_w,
   input  logic [SW-1:0]                        side_h,
   output logic                                 wr_en,
   output logic [2*CW-1:0]                      wr_addr,
   output logic [rrc_pkg::CHAR_W-1:0]           wr_data,
   output logic                                 done
);

   localparam int CMP_W = ((CW + FRAC_BITS + 3) > 28) ? (CW + FRAC_BITS + 3) : 28;
   localparam logic signed [CMP_W-1:0] ONE = CMP_W'(1) << FRAC_BITS;

   logic                       busy_ff;
   logic                       clear_ff;
   logic                       fill_ff;
   logic [rrc_pkg::CHAR_W-1:0] color_ff;
   logic [SW-1:0]              w_ff, h_ff;
   logic [CW-1:0]              x_ff, y_ff;
   logic signed [CMP_W-1:0]    l_ff, r_ff, t_ff, b_ff;

   logic signed [CMP_W-1:0]    px, pxp, pxm, py, pyp, pym;
   logic                       in_box, border, last_x, last_y;

   // Pixel position and its neighbors one unit away, in fixed point
   always_comb begin
      px  = signed'(CMP_W'(x_ff)) <<< FRAC_BITS;
      py  = signed'(CMP_W'(y_ff)) <<< FRAC_BITS;
      pxp = px + ONE;
      pxm = px - ONE;
      pyp = py + ONE;
      pym = py - ONE;
      in_box = (px >= l_ff) && (px <= r_ff) && (py >= t_ff) && (py <= b_ff);
      // less than one unit from an edge
      border = in_box && ((pxm < l_ff) || (pxp > r_ff) || (pym < t_ff) || (pyp > b_ff));
      last_x = (SW'(x_ff) == (w_ff - SW'(1)));
      last_y = (SW'(y_ff) == (h_ff - SW'(1)));
   end

   assign wr_en   = busy_ff && (clear_ff || border || (fill_ff && in_box));
   assign wr_addr = {y_ff, x_ff};
   assign wr_data = color_ff;
   assign done    = busy_ff && last_x && last_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         x_ff    <= '0;
         y_ff    <= '0;
      end else if (cmd.start) begin
         busy_ff  <= 1'b1;
         x_ff     <= '0;
         y_ff     <= '0;
         clear_ff <= cmd.clear;
         fill_ff  <= cmd.fill;
         color_ff <= cmd.color;
         w_ff     <= side_w;
         h_ff     <= side_h;
         l_ff     <= CMP_W'(rect_left);
         t_ff     <= CMP_W'(rect_top);
         r_ff     <= CMP_W'(rect_left) + CMP_W'(rect_width);
         b_ff     <= CMP_W'(rect_top) + CMP_W'(rect_height);
      end else if (busy_ff) begin
         if (last_x) begin
            x_ff <= '0;
            if (last_y) begin
               busy_ff <= 1'b0;
               y_ff    <= '0;
            end else begin
               y_ff <= y_ff + CW'(1);
            end
         end else begin
            x_ff <= x_ff + CW'(1);
         end
      end
   end

endmodule

// File: rtl/rectangle_raster_canvas.sv
// A clear, or a paint with a positive size, is answered once the raster sweep has passed
//   all w x h pixels of the canvas size in use; a read in range passes the read and
//   capture states, any other request goes straight to done. One request at a time;
//   the sweep visits one pixel per cycle, writing through the single canvas write port.
// Reset: synchronous, active high; sets size 256 x 256 and background 46, and leaves
//   the canvas contents as they are (undefined until the first clear).
module rectangle_raster_canvas #(
   parameter int MAX_SIDE  = rrc_pkg::MAX_SIDE_DEF,
   parameter int FRAC_BITS = rrc_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata: rect_left[23:0], rect_top[47:24], rect_width[71:48], rect_height[95:72],
   //        filled[96], color[104:97], pixel_col[112:105], pixel_row[120:113], zero pad
   input  logic [rrc_pkg::REQ_DATA_W-1:0]        req_tdata,
   // tuser: mode[1:0]
   input  logic [1:0]                            req_tuser,
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata: pixel[7:0]
   output logic [rrc_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // tuser: status[1:0]
   output logic [1:0]                            rsp_tuser,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rrc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rrc_pkg::CFG_W-1:0]             csr_data
);

   localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int SW    = $clog2(MAX_SIDE + 1);
   localparam int IDX_W = (SW > rrc_pkg::POS_W) ? SW : rrc_pkg::POS_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_READ,
      ST_CAPTURE,
      ST_DONE
   } state_type;

   // ---------------------------------------------------------------------------
   // Configuration registers; the user writes only while idle (not enforced), taken at once
   // ---------------------------------------------------------------------------
   logic [rrc_pkg::CFG_W-1:0]  cfg_w_ff;
   logic [rrc_pkg::CFG_W-1:0]  cfg_h_ff;
   logic [rrc_pkg::CHAR_W-1:0] bg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= rrc_pkg::CANVAS_WIDTH_RST;
         cfg_h_ff <= rrc_pkg::CANVAS_HEIGHT_RST;
         bg_ff    <= rrc_pkg::BACKGROUND_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rrc_pkg::CSR_CANVAS_WIDTH:  cfg_w_ff <= csr_data;
            rrc_pkg::CSR_CANVAS_HEIGHT: cfg_h_ff <= csr_data;
            rrc_pkg::CSR_BACKGROUND:    bg_ff    <= csr_data[rrc_pkg::CHAR_W-1:0];
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   // Size in use: zero counts as one, anything above the storage side as the side
   logic [SW-1:0] side_w, side_h;

   always_comb begin
      if (cfg_w_ff == '0) begin
         side_w = SW'(1);
      end else if (int'(cfg_w_ff) > MAX_SIDE) begin
         side_w = SW'(MAX_SIDE);
      end else begin
         side_w = SW'(cfg_w_ff);
      end
      if (cfg_h_ff == '0) begin
         side_h = SW'(1);
      end else if (int'(cfg_h_ff) > MAX_SIDE) begin
         side_h = SW'(MAX_SIDE);
      end else begin
         side_h = SW'(cfg_h_ff);
      end
   end

   // ---------------------------------------------------------------------------
   // Request fields
   // ---------------------------------------------------------------------------
   rrc_pkg::mode_type                    req_mode;
   logic signed [rrc_pkg::COORD_W-1:0]   req_left, req_top, req_width, req_height;
   logic                                 req_filled;
   logic [rrc_pkg::CHAR_W-1:0]           req_color;
   logic [IDX_W-1:0]                     req_col, req_row;
   logic                                 req_accept, req_reject, req_outside;

   assign req_mode   = rrc_pkg::mode_type'(req_tuser);
   assign req_left   = req_tdata[rrc_pkg::LEFT_LSB   +: rrc_pkg::COORD_W];
   assign req_top    = req_tdata[rrc_pkg::TOP_LSB    +: rrc_pkg::COORD_W];
   assign req_width  = req_tdata[rrc_pkg::WIDTH_LSB  +: rrc_pkg::COORD_W];
   assign req_height = req_tdata[rrc_pkg::HEIGHT_LSB +: rrc_pkg::COORD_W];
   assign req_filled = req_tdata[rrc_pkg::FILLED_BIT];
   assign req_color  = req_tdata[rrc_pkg::COLOR_LSB  +: rrc_pkg::CHAR_W];
   assign req_col    = IDX_W'(req_tdata[rrc_pkg::COL_LSB +: rrc_pkg::POS_W]);
   assign req_row    = IDX_W'(req_tdata[rrc_pkg::ROW_LSB +: rrc_pkg::POS_W]);

   // Empty or negative size rejects a paint, which leaves the canvas alone
   assign req_reject  = (req_width <= 0) || (req_height <= 0);
   assign req_outside = (req_col >= IDX_W'(side_w)) || (req_row >= IDX_W'(side_h));

   // ---------------------------------------------------------------------------
   // Raster sweep and canvas memory
   // ---------------------------------------------------------------------------
   state_type                  state_ff;
   rrc_pkg::sweep_cmd_type     sweep_cmd;
   logic                       sweep_done;
   logic                       mem_wr_en, mem_rd_en;
   logic [2*CW-1:0]            mem_wr_addr;
   logic [rrc_pkg::CHAR_W-1:0] mem_wr_data, mem_rd_data;
   logic [2*CW-1:0]            rd_addr_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // Start a sweep for a clear, or for a paint with a positive size
   always_comb begin
      sweep_cmd.start = req_accept &&
                        ((req_mode == rrc_pkg::MODE_CLEAR) ||
                         ((req_mode == rrc_pkg::MODE_PAINT) && !req_reject));
      sweep_cmd.clear = (req_mode == rrc_pkg::MODE_CLEAR);
      sweep_cmd.fill  = req_filled;
      sweep_cmd.color = (req_mode == rrc_pkg::MODE_CLEAR) ? bg_ff : req_color;
   end

   rrc_sweep #(
      .MAX_SIDE  (MAX_SIDE),
      .FRAC_BITS (FRAC_BITS)
   ) u_sweep (
      .clock       (clock),
      .reset       (reset),
      .cmd         (sweep_cmd),
      .rect_left   (req_left),
      .rect_top    (req_top),
      .rect_width  (req_width),
      .rect_height (req_height),
      .side_w      (side_w),
      .side_h      (side_h),
      .wr_en       (mem_wr_en),
      .wr_addr     (mem_wr_addr),
      .wr_data     (mem_wr_data),
      .done        (sweep_done)
   );

   assign mem_rd_en = (state_ff == ST_READ);

   rrc_canvas_mem #(
      .ADDR_W (2 * CW)
   ) u_canvas (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (mem_rd_data)
   );

   // ---------------------------------------------------------------------------
   // Request control and response register. The response register lets a new
   // request in while the previous response still waits for rsp_tready.
   // ---------------------------------------------------------------------------
   rrc_pkg::status_type        res_status_ff;
   logic [rrc_pkg::CHAR_W-1:0] res_pixel_ff;
   logic                       rsp_tvalid_ff;
   rrc_pkg::status_type        rsp_status_ff;
   logic [rrc_pkg::CHAR_W-1:0] rsp_pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // drop a taken response unless a new one replaces it below
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  res_status_ff <= rrc_pkg::STAT_OK;
                  res_pixel_ff  <= '0;
                  unique case (req_mode)
                     rrc_pkg::MODE_CLEAR: state_ff <= ST_SWEEP;
                     rrc_pkg::MODE_PAINT: begin
                        if (req_reject) begin
                           res_status_ff <= rrc_pkg::STAT_REJECT;
                           state_ff      <= ST_DONE;
                        end else begin
                           state_ff <= ST_SWEEP;
                        end
                     end
                     rrc_pkg::MODE_READ: begin
                        if (req_outside) begin
                           res_status_ff <= rrc_pkg::STAT_OUTSIDE;
                           state_ff      <= ST_DONE;
                        end else begin
                           rd_addr_ff <= {req_row[CW-1:0], req_col[CW-1:0]};
                           state_ff   <= ST_READ;
                        end
                     end
                     default: state_ff <= ST_DONE; // unused mode answers ok, pixel 0
                  endcase
               end
            end
            ST_SWEEP: begin
               if (sweep_done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_READ: state_ff <= ST_CAPTURE;
            ST_CAPTURE: begin
               res_pixel_ff <= mem_rd_data;
               state_ff     <= ST_DONE;
            end
            ST_DONE: begin
               // hold the result until the response register is free
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_pixel_ff  <= res_pixel_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tuser  = rsp_status_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_write_only_in_sweep: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_SWEEP))
      else $error("canvas written outside a sweep");

   a_done_only_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweep_done |-> (state_ff == ST_SWEEP))
      else $error("sweep finished while control not sweeping");

   a_no_read_during_write: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("canvas read and written in the same cycle");

   a_capture_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CAPTURE) |-> ($past(state_ff) == ST_READ))
      else $error("read data captured without a read");

   a_response_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised without a finished request");

endmodule
